FILE: src/stepper_phase_sequencer_macros.svh
// Assertion shorthands for the stepper phase sequencer.
`ifndef STEPPER_PHASE_SEQUENCER_MACROS_SVH
`define STEPPER_PHASE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sps_pkg.sv
`default_nettype none

package sps_pkg;

    typedef enum logic [2:0] {
        CMD_STEP         = 3'd0,
        CMD_ENABLE       = 3'd1,
        CMD_HOLD_STOP    = 3'd2,
        CMD_RELEASE_STOP = 3'd3,
        CMD_INVERT       = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_FOUR_COIL = 2'd0,
        MODE_TWO_COIL  = 2'd1,
        MODE_STEP_DIR  = 2'd2
    } drive_mode_t;

    typedef enum logic [1:0] {
        REG_DRIVE_MODE   = 2'd0,
        REG_HALF_STEP    = 2'd1,
        REG_ENDSTOP_USED = 2'd2,
        REG_HOLD_ON_IDLE = 2'd3
    } reg_idx_t;

    localparam int unsigned ADDR_BITS = 4;
    localparam int unsigned DATA_BITS = 32;

    localparam logic [3:0] TWO_COIL_MASK = 4'h5;

    localparam logic [3:0] FULL_TAB [4] = '{4'h5, 4'h6, 4'hA, 4'h9};
    localparam logic [3:0] HALF_TAB [8] = '{4'h1, 4'h5, 4'h4, 4'h6,
                                            4'h2, 4'hA, 4'h8, 4'h9};

    typedef struct packed {
        logic [1:0] drive_mode;
        logic       half_step;
        logic       endstop_used;
        logic       hold_on_idle;
    } cfg_t;

    typedef struct packed {
        logic [2:0] command;
        logic       step_dir;
        logic       endstop_level;
        logic       last_of_move;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0]         coil_pattern;
        logic               step_pulse;
        logic               dir_level;
        logic               enable_n;
        logic signed [31:0] position_out;
        logic               endstop_hit;
        logic               stepped;
    } res_item_t;

endpackage

`default_nettype wire

FILE: src/sps_ifs.sv
`default_nettype none

interface sps_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic       step_dir;
    logic       endstop_level;
    logic       last_of_move;

    modport source (output valid, command, step_dir, endstop_level, last_of_move,
                    input ready);
    modport sink   (input valid, command, step_dir, endstop_level, last_of_move,
                    output ready);
endinterface

interface sps_res_if;
    logic               valid;
    logic               ready;
    logic [3:0]         coil_pattern;
    logic               step_pulse;
    logic               dir_level;
    logic               enable_n;
    logic signed [31:0] position_out;
    logic               endstop_hit;
    logic               stepped;

    modport source (output valid, coil_pattern, step_pulse, dir_level, enable_n,
                    position_out, endstop_hit, stepped,
                    input ready);
    modport sink   (input valid, coil_pattern, step_pulse, dir_level, enable_n,
                    position_out, endstop_hit, stepped,
                    output ready);
endinterface

`default_nettype wire

FILE: src/stepper_phase_sequencer.sv
// Channel | Dir | Transaction
// cmd     | in  | command, step_dir, endstop_level, last_of_move
// res     | out | coil_pattern, step_pulse, dir_level, enable_n,
//         |     | position_out, endstop_hit, stepped
// APB     | in  | register writes/reads, one per setup+access pair
//
// One transaction per cycle sustained while res is not stalled; a result is valid
// after its command passes the input register, then one pass of core logic
// into the result register. The core state advances as the result register loads.
// Stall on res holds both stages; cmd.ready stays high while the input
// register can move. Reset clears state, config and valids; data registers
// load only with a transaction.
`default_nettype none

module stepper_phase_sequencer
    import sps_pkg::*;
#(
    parameter int unsigned POSITION_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready,
    sps_cmd_if.sink                   cmd,
    sps_res_if.source                 res
);

    cfg_t      cfg;
    cmd_item_t item_reg;
    logic      in_valid_reg;
    res_item_t res_reg;
    res_item_t res_next;
    logic      out_valid_reg;
    logic      advance;
    logic      take;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign take      = cmd.valid && cmd.ready;

    sps_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sps_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .item  (item_reg),
        .fire  (advance),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.command       <= cmd.command;
            item_reg.step_dir      <= cmd.step_dir;
            item_reg.endstop_level <= cmd.endstop_level;
            item_reg.last_of_move  <= cmd.last_of_move;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.coil_pattern = res_reg.coil_pattern;
    assign res.step_pulse   = res_reg.step_pulse;
    assign res.dir_level    = res_reg.dir_level;
    assign res.enable_n     = res_reg.enable_n;
    assign res.position_out = res_reg.position_out;
    assign res.endstop_hit  = res_reg.endstop_hit;
    assign res.stepped      = res_reg.stepped;

endmodule

`default_nettype wire

FILE: src/sps_cfg_regs.sv
`default_nettype none

module sps_cfg_regs
    import sps_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready,
    output cfg_t                      cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_DRIVE_MODE:   cfg_next.drive_mode   = pwdata[1:0];
                REG_HALF_STEP:    cfg_next.half_step    = pwdata[0];
                REG_ENDSTOP_USED: cfg_next.endstop_used = pwdata[0];
                REG_HOLD_ON_IDLE: cfg_next.hold_on_idle = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_DRIVE_MODE:   prdata[1:0] = cfg_reg.drive_mode;
            REG_HALF_STEP:    prdata[0]   = cfg_reg.half_step;
            REG_ENDSTOP_USED: prdata[0]   = cfg_reg.endstop_used;
            REG_HOLD_ON_IDLE: prdata[0]   = cfg_reg.hold_on_idle;
            default:          prdata      = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_mode   <= MODE_FOUR_COIL;
            cfg_reg.half_step    <= 1'b0;
            cfg_reg.endstop_used <= 1'b0;
            cfg_reg.hold_on_idle <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/sps_core.sv
`default_nettype none

module sps_core
    import sps_pkg::*;
#(
    parameter int unsigned POSITION_BITS = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire cmd_item_t item,
    input  wire logic      fire,
    output res_item_t      res
);

    logic [2:0]               phase_reg, phase_next;
    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic                     run_en_reg, run_en_next;
    logic                     dir_inv_reg, dir_inv_next;
    logic                     at_es_reg, at_es_next;
    logic [3:0]               coil_reg, coil_next;
    logic                     dir_pin_reg, dir_pin_next;
    logic                     en_pin_reg, en_pin_next;

    logic                     ext_mode;
    logic                     half;
    logic                     ccw;
    logic [2:0]               phase_adv;
    logic                     pulse;
    logic                     moved;
    logic signed [31:0]       pos32;

    assign ext_mode = cfg.drive_mode[1];
    assign half     = cfg.half_step && (drive_mode_t'(cfg.drive_mode) == MODE_FOUR_COIL);
    assign ccw      = item.step_dir ^ dir_inv_reg;

    always_comb
    begin
        if (half)
            phase_adv = phase_reg + (ccw ? 3'd7 : 3'd1);
        else
            phase_adv = {1'b0, phase_reg[1:0] + (ccw ? 2'd3 : 2'd1)};
    end

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        run_en_next  = run_en_reg;
        dir_inv_next = dir_inv_reg;
        at_es_next   = at_es_reg;
        coil_next    = coil_reg;
        dir_pin_next = dir_pin_reg;
        en_pin_next  = en_pin_reg;
        pulse        = 1'b0;
        moved        = 1'b0;

        unique case (cmd_t'(item.command))
            CMD_STEP:
            begin
                if (run_en_reg)
                begin
                    if (cfg.endstop_used && !item.endstop_level)
                    begin
                        at_es_next = 1'b1;
                        if (ext_mode)
                            en_pin_next = 1'b1;
                        else
                            coil_next = 4'h0;
                    end
                    else
                    begin
                        if (ext_mode)
                        begin
                            en_pin_next  = 1'b0;
                            dir_pin_next = !ccw;
                            pulse        = 1'b1;
                        end
                        else
                        begin
                            phase_next = phase_adv;
                            coil_next  = half ? HALF_TAB[phase_adv] : FULL_TAB[phase_adv[1:0]];
                        end
                        count_next = count_reg + (ccw ? {POSITION_BITS{1'b1}}
                                                      : POSITION_BITS'(1));
                        moved = 1'b1;
                        if (item.last_of_move && !cfg.hold_on_idle)
                        begin
                            if (ext_mode)
                                en_pin_next = 1'b1;
                            else
                                coil_next = 4'h0;
                        end
                    end
                end
            end
            CMD_ENABLE:    run_en_next = 1'b1;
            CMD_HOLD_STOP: run_en_next = 1'b0;
            CMD_RELEASE_STOP:
            begin
                run_en_next = 1'b0;
                if (ext_mode)
                    en_pin_next = 1'b1;
                else
                    coil_next = 4'h0;
            end
            CMD_INVERT:    dir_inv_next = !dir_inv_reg;
            default:       moved = 1'b0;
        endcase
    end

    generate
        if (POSITION_BITS >= 32)
        begin : g_pos_trunc
            assign pos32 = count_next[31:0];
        end
        else
        begin : g_pos_sext
            assign pos32 = {{(32-POSITION_BITS){count_next[POSITION_BITS-1]}}, count_next};
        end
    endgenerate

    always_comb
    begin
        res.position_out = pos32;
        res.endstop_hit  = at_es_next;
        res.stepped      = moved;
        if (ext_mode)
        begin
            res.coil_pattern = 4'h0;
            res.step_pulse   = pulse;
            res.dir_level    = dir_pin_next;
            res.enable_n     = en_pin_next;
        end
        else
        begin
            if (drive_mode_t'(cfg.drive_mode) == MODE_TWO_COIL)
                res.coil_pattern = coil_next & TWO_COIL_MASK;
            else
                res.coil_pattern = coil_next;
            res.step_pulse = 1'b0;
            res.dir_level  = 1'b0;
            res.enable_n   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            count_reg   <= '0;
            run_en_reg  <= 1'b1;
            dir_inv_reg <= 1'b0;
            at_es_reg   <= 1'b0;
            coil_reg    <= 4'h0;
            dir_pin_reg <= 1'b1;
            en_pin_reg  <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            run_en_reg  <= run_en_next;
            dir_inv_reg <= dir_inv_next;
            at_es_reg   <= at_es_next;
            coil_reg    <= coil_next;
            dir_pin_reg <= dir_pin_next;
            en_pin_reg  <= en_pin_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/sps_checker.sv
`default_nettype none
`include "stepper_phase_sequencer_macros.svh"

module sps_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               res_valid,
    input wire logic               res_ready,
    input wire logic [3:0]         coil_pattern,
    input wire logic               step_pulse,
    input wire logic               dir_level,
    input wire logic               enable_n,
    input wire logic signed [31:0] position_out,
    input wire logic               stepped
);

    // a pulse is only ever given with a real step, never with coil drive
    `SPS_ASSERT_IMP(a_pulse_means_step, clk, rst_n, res_valid && step_pulse, stepped && coil_pattern == 4'h0, "step pulse without step")

    // coil lines are driven only in coil modes, where step/dir pins idle
    `SPS_ASSERT_IMP(a_coil_mode_pins, clk, rst_n, res_valid && coil_pattern != 4'h0, enable_n && !step_pulse && !dir_level, "coil drive in step/dir mode")

    // no pulse may appear on a result that did not move
    `SPS_ASSERT_IMP(a_no_move_no_pulse, clk, rst_n, res_valid && !stepped, !step_pulse, "pulse without movement")

    `SPS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(position_out) && $stable(coil_pattern), "stalled result changed")

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .coil_pattern (res.coil_pattern),
    .step_pulse   (res.step_pulse),
    .dir_level    (res.dir_level),
    .enable_n     (res.enable_n),
    .position_out (res.position_out),
    .stepped      (res.stepped)
);

`default_nettype wire

FILE: sim/stepper_phase_sequencer_tb.sv
`default_nettype none

module stepper_phase_sequencer_tb
    import sps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned CHOKE_AFTER = 400;
    localparam int unsigned CHOKE_LEN   = 300;

    localparam logic [1:0]  MODE_STEP_DIR_ALT = 2'd3;
    localparam logic [2:0]  CMD_UNUSED_FIRST  = CMD_INVERT + 3'd1;

    // coil patterns, one nibble per phase
    localparam logic [15:0] FULL_PHASES = 16'h9A65;
    localparam logic [31:0] HALF_PHASES = 32'h98A26451;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [DATA_BITS-1:0] pwdata  = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    sps_cmd_if cmd_if();
    sps_res_if res_if();

    logic      src_valid  = 1'b0;
    cmd_item_t drv_item   = '0;
    logic      sink_ready = 1'b0;

    assign cmd_if.valid         = src_valid;
    assign cmd_if.command       = drv_item.command;
    assign cmd_if.step_dir      = drv_item.step_dir;
    assign cmd_if.endstop_level = drv_item.endstop_level;
    assign cmd_if.last_of_move  = drv_item.last_of_move;
    assign res_if.ready         = sink_ready;

    stepper_phase_sequencer #(
        .POSITION_BITS(32)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cmd    (cmd_if),
        .res    (res_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // configuration copy
    logic [1:0] cfg_mode    = MODE_FOUR_COIL;
    logic       cfg_half    = 1'b0;
    logic       cfg_endstop = 1'b0;
    logic       cfg_hold    = 1'b1;

    // motor state copy
    logic [2:0]  phase_now       = '0;
    logic [31:0] position_now    = '0;
    logic        motion_enabled  = 1'b1;
    logic        dir_flip        = 1'b0;
    logic        endstop_latched = 1'b0;
    logic [3:0]  coil_now        = '0;
    logic        dir_pin_now     = 1'b1;
    logic        enable_pin_now  = 1'b1;

    cmd_item_t cmd_backlog[$];
    res_item_t expected_outputs[$];

    int n_queued   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;

    task automatic release_drive();
        if (cfg_mode[1])
            enable_pin_now = 1'b1;
        else
            coil_now = 4'h0;
    endtask

    task automatic predict_drive_outputs(input cmd_item_t it);
        res_item_t  r;
        logic       pulse;
        logic       moved;
        logic       ccw;
        logic [1:0] p4;
        begin
            pulse = 1'b0;
            moved = 1'b0;
            case (it.command)
                CMD_STEP:
                begin
                    if (motion_enabled) begin
                        if (cfg_endstop && !it.endstop_level) begin
                            release_drive();
                            endstop_latched = 1'b1;
                        end else begin
                            ccw = it.step_dir ^ dir_flip;
                            if (cfg_mode[1]) begin
                                enable_pin_now = 1'b0;
                                dir_pin_now    = !ccw;
                                pulse          = 1'b1;
                            end else if (cfg_half && cfg_mode == MODE_FOUR_COIL) begin
                                phase_now = ccw ? phase_now - 3'd1 : phase_now + 3'd1;
                                coil_now  = HALF_PHASES[{phase_now, 2'b00} +: 4];
                            end else begin
                                p4        = ccw ? phase_now[1:0] - 2'd1 : phase_now[1:0] + 2'd1;
                                phase_now = {1'b0, p4};
                                coil_now  = FULL_PHASES[{p4, 2'b00} +: 4];
                            end
                            position_now = ccw ? position_now - 32'd1 : position_now + 32'd1;
                            moved = 1'b1;
                            if (it.last_of_move && !cfg_hold)
                                release_drive();
                        end
                    end
                end
                CMD_ENABLE:       motion_enabled = 1'b1;
                CMD_HOLD_STOP:    motion_enabled = 1'b0;
                CMD_RELEASE_STOP:
                begin
                    motion_enabled = 1'b0;
                    release_drive();
                end
                CMD_INVERT:       dir_flip = !dir_flip;
                default: ;
            endcase

            if (cfg_mode[1]) begin
                r.coil_pattern = 4'h0;
                r.step_pulse   = pulse;
                r.dir_level    = dir_pin_now;
                r.enable_n     = enable_pin_now;
            end else begin
                r.coil_pattern = (cfg_mode == MODE_TWO_COIL) ? (coil_now & 4'h5) : coil_now;
                r.step_pulse   = 1'b0;
                r.dir_level    = 1'b0;
                r.enable_n     = 1'b1;
            end
            r.position_out = position_now;
            r.endstop_hit  = endstop_latched;
            r.stepped      = moved;
            expected_outputs.push_back(r);
        end
    endtask

    // command driver
    int   src_gap   = 0;
    logic src_nogap = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n) begin
            src_valid <= 1'b0;
            src_gap   <= 0;
        end else begin
            if (src_valid && cmd_if.ready) begin
                predict_drive_outputs(drv_item);
                n_accepted++;
            end
            if (!src_valid || cmd_if.ready) begin
                if (src_gap != 0) begin
                    src_gap   <= src_gap - 1;
                    src_valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    drv_item  <= cmd_backlog.pop_front();
                    src_valid <= 1'b1;
                    src_gap   <= src_nogap ? 0 : int'($urandom_range(0, 7));
                    if ($urandom_range(0, 47) == 0)
                        src_nogap <= !src_nogap;
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // result monitor
    int   snk_wait   = 0;
    logic snk_nogap  = 1'b0;
    int   choke_left = 0;
    logic choked     = 1'b0;

    always @(posedge clk)
    begin
        res_item_t got;
        res_item_t want;
        int        d;
        if (!rst_n) begin
            sink_ready <= 1'b0;
            snk_wait   <= 0;
        end else begin
            if (res_if.valid && sink_ready) begin
                got.coil_pattern = res_if.coil_pattern;
                got.step_pulse   = res_if.step_pulse;
                got.dir_level    = res_if.dir_level;
                got.enable_n     = res_if.enable_n;
                got.position_out = res_if.position_out;
                got.endstop_hit  = res_if.endstop_hit;
                got.stepped      = res_if.stepped;
                if (expected_outputs.size() == 0) begin
                    $display("%0t: unexpected transaction: expected none, actual %p", $time, got);
                    n_errors++;
                end else begin
                    want = expected_outputs.pop_front();
                    check_field("coil_pattern", 32'(want.coil_pattern), 32'(got.coil_pattern));
                    check_field("step_pulse",   32'(want.step_pulse),   32'(got.step_pulse));
                    check_field("dir_level",    32'(want.dir_level),    32'(got.dir_level));
                    check_field("enable_n",     32'(want.enable_n),     32'(got.enable_n));
                    check_field("position_out", want.position_out,      got.position_out);
                    check_field("endstop_hit",  32'(want.endstop_hit),  32'(got.endstop_hit));
                    check_field("stepped",      32'(want.stepped),      32'(got.stepped));
                end
                n_results++;
            end

            if (choke_left != 0) begin
                choke_left <= choke_left - 1;
                sink_ready <= (choke_left == 1);
            end else if (!choked && n_results >= CHOKE_AFTER) begin
                choked     <= 1'b1;
                choke_left <= CHOKE_LEN;
                sink_ready <= 1'b0;
            end else if (res_if.valid && sink_ready) begin
                d = snk_nogap ? 0 : int'($urandom_range(0, 7));
                snk_wait   <= d;
                sink_ready <= (d == 0);
                if ($urandom_range(0, 47) == 0)
                    snk_nogap <= !snk_nogap;
            end else if (snk_wait != 0) begin
                snk_wait   <= snk_wait - 1;
                sink_ready <= (snk_wait == 1);
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

    // watchdog
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((src_valid && cmd_if.ready) || (res_if.valid && sink_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("stepper_phase_sequencer test failed");
            $finish;
        end
    end

    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val,
                             input logic [31:0] field_mask);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (32'($urandom) & ~field_mask) | (val & field_mask);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DRIVE_MODE:   cfg_mode    = val[1:0];
            REG_HALF_STEP:    cfg_half    = val[0];
            REG_ENDSTOP_USED: cfg_endstop = val[0];
            REG_HOLD_ON_IDLE: cfg_hold    = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] mode, input logic half,
                              input logic es, input logic hold);
        cfg_write(REG_DRIVE_MODE,   32'(mode), 32'h3);
        cfg_write(REG_HALF_STEP,    32'(half), 32'h1);
        cfg_write(REG_ENDSTOP_USED, 32'(es),   32'h1);
        cfg_write(REG_HOLD_ON_IDLE, 32'(hold), 32'h1);
    endtask

    task automatic push_cmd(input logic [2:0] c, input logic dir, input logic lvl,
                            input logic last);
        cmd_item_t it;
        it.command       = c;
        it.step_dir      = dir;
        it.endstop_level = lvl;
        it.last_of_move  = last;
        cmd_backlog.push_back(it);
        n_queued++;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (n_accepted != n_queued || expected_outputs.size() != 0);
    endtask

    function automatic logic endstop_sample();
        if (cfg_endstop)
            return ($urandom_range(0, 31) != 0);
        return 1'($urandom);
    endfunction

    task automatic queue_random_moves(input int n_items);
        int   count;
        int   r;
        int   len;
        int   k;
        logic dir;
        count = 0;
        while (count < n_items) begin
            r = $urandom_range(0, 19);
            if (r < 14) begin
                len = $urandom_range(1, 12);
                dir = 1'($urandom);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 15) == 0)
                        dir = !dir;
                    push_cmd(CMD_STEP, dir, endstop_sample(),
                             (k == len - 1) || ($urandom_range(0, 15) == 0));
                end
                count += len;
            end else if (r == 14) begin
                push_cmd(CMD_ENABLE, 1'($urandom), 1'($urandom), 1'($urandom));
                count++;
            end else if (r == 15 || r == 16) begin
                push_cmd((r == 15) ? CMD_HOLD_STOP : CMD_RELEASE_STOP,
                         1'($urandom), 1'($urandom), 1'($urandom));
                len = $urandom_range(0, 2);
                for (k = 0; k < len; k++)
                    push_cmd(CMD_STEP, 1'($urandom), endstop_sample(), 1'($urandom));
                count += len + 1;
                if ($urandom_range(0, 3) != 0) begin
                    push_cmd(CMD_ENABLE, 1'($urandom), 1'($urandom), 1'($urandom));
                    count++;
                end
            end else if (r == 17) begin
                push_cmd(CMD_INVERT, 1'($urandom), 1'($urandom), 1'($urandom));
                count++;
            end else begin
                push_cmd(3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
                count++;
            end
        end
    endtask

    task automatic random_phase(input logic [1:0] mode, input logic half,
                                input logic es, input logic hold);
        set_config(mode, half, es, hold);
        queue_random_moves(190);
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // four coils, full step, coils released at end of move
        set_config(MODE_FOUR_COIL, 1'b0, 1'b0, 1'b0);
        push_cmd(CMD_STEP, 1'b0, 1'b1, 1'b0);
        push_cmd(CMD_STEP, 1'b0, 1'b0, 1'b0);
        push_cmd(CMD_STEP, 1'b1, 1'b1, 1'b0);
        push_cmd(CMD_STEP, 1'b1, 1'b1, 1'b0);
        push_cmd(CMD_STEP, 1'b1, 1'b1, 1'b0);
        push_cmd(CMD_STEP, 1'b0, 1'b1, 1'b1);
        push_cmd(CMD_HOLD_STOP, 1'b0, 1'b1, 1'b0);
        push_cmd(CMD_STEP, 1'b0, 1'b1, 1'b1);
        push_cmd(CMD_ENABLE, 1'b0, 1'b1, 1'b0);
        push_cmd(CMD_INVERT, 1'b0, 1'b1, 1'b0);
        push_cmd(CMD_STEP, 1'b0, 1'b1, 1'b0);
        push_cmd(CMD_INVERT, 1'b1, 1'b0, 1'b1);
        push_cmd(CMD_RELEASE_STOP, 1'b0, 1'b1, 1'b0);
        push_cmd(CMD_STEP, 1'b1, 1'b1, 1'b0);
        push_cmd(CMD_UNUSED_FIRST, 1'b1, 1'b1, 1'b1);
        push_cmd(CMD_UNUSED_FIRST + 3'd1, 1'b0, 1'b0, 1'b0);
        push_cmd(CMD_UNUSED_FIRST + 3'd2, 1'b1, 1'b0, 1'b1);
        push_cmd(CMD_ENABLE, 1'b1, 1'b1, 1'b1);
        drain();

        // half step, hold on idle, pressed endstop ignored while unused
        set_config(MODE_FOUR_COIL, 1'b1, 1'b0, 1'b1);
        push_cmd(CMD_STEP, 1'b0, 1'b1, 1'b0);
        push_cmd(CMD_STEP, 1'b0, 1'b1, 1'b1);
        push_cmd(CMD_STEP, 1'b0, 1'b0, 1'b0);
        drain();

        // two coils ignore half step; odd phase left from the half table
        set_config(MODE_TWO_COIL, 1'b1, 1'b0, 1'b1);
        push_cmd(CMD_STEP, 1'b0, 1'b1, 1'b0);
        push_cmd(CMD_STEP, 1'b1, 1'b1, 1'b0);
        drain();

        // mode three acts as step/dir
        set_config(MODE_STEP_DIR_ALT, 1'b0, 1'b0, 1'b0);
        push_cmd(CMD_STEP, 1'b0, 1'b1, 1'b0);
        push_cmd(CMD_STEP, 1'b1, 1'b1, 1'b1);
        drain();

        random_phase(MODE_FOUR_COIL,    1'b0, 1'b0, 1'b1);
        random_phase(MODE_FOUR_COIL,    1'b1, 1'b0, 1'b0);
        random_phase(MODE_TWO_COIL,     1'b0, 1'b0, 1'b1);
        random_phase(MODE_STEP_DIR,     1'b0, 1'b0, 1'b0);
        random_phase(MODE_STEP_DIR_ALT, 1'b1, 1'b0, 1'b1);
        random_phase(MODE_FOUR_COIL,    1'b1, 1'b1, 1'b0);
        random_phase(MODE_STEP_DIR,     1'b1, 1'b1, 1'b1);
        random_phase(MODE_TWO_COIL,     1'b1, 1'b1, 1'b0);

        repeat (10) @(posedge clk);
        if (n_errors == 0 && expected_outputs.size() == 0) begin
            $display("stepper_phase_sequencer test passed");
        end else begin
            $display("%0t: %0d mismatches, %0d transactions still expected",
                     $time, n_errors, expected_outputs.size());
            $display("stepper_phase_sequencer test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
